@@ hdl/rhpu_pkg.sv @@
// Shared types, widths, register indexes and the CORDIC angle table
// for the ring hit test / polar texture pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rhpu_pkg;

    localparam int COORD_BITS = 16;                  // Q8.8 point and center fields
    localparam int AXIS_BITS  = 16;                  // Q1.14 axis fields
    localparam int VEC_BITS   = 3 * COORD_BITS;      // packed x,y,z
    localparam int CFG_BITS   = 48;                  // widest register
    localparam int DIFF_W     = COORD_BITS + 1;      // point - center
    localparam int SQ_W       = 2 * COORD_BITS;      // one squared term
    localparam int D2_W       = SQ_W + 2;            // sum of three squares
    localparam int PROD_W     = DIFF_W + AXIS_BITS;  // one axis product
    localparam int PROJ_W     = PROD_W + 2;          // sum of three products
    localparam int RAD_W      = 16;
    localparam int ANG_W      = 16;

    // sqrt of d2 << 16: one root bit per stage
    localparam int SQRT_IN_W  = D2_W + 16;
    localparam int ROOT_W     = SQRT_IN_W / 2;
    localparam int REM_W      = ROOT_W + 2;

    localparam int CORDIC_STEPS = 20;
    localparam int CORD_W       = PROJ_W + 11;       // scaled by 256, plus growth
    localparam int TURN_W       = 32;

    // pipeline depths
    localparam int FRONT_LAT  = 3;
    localparam int SQRT_LAT   = ROOT_W;
    localparam int DIV_LAT    = RAD_W + 1;
    localparam int CORD_LAT   = CORDIC_STEPS + 1;
    localparam int TOTAL_LAT  = FRONT_LAT + SQRT_LAT + DIV_LAT;
    localparam int HIT_DLY    = TOTAL_LAT - FRONT_LAT;
    localparam int ANG_DLY    = TOTAL_LAT - FRONT_LAT - CORD_LAT;

    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_CENTER = 3'd0;
    localparam logic [IDX_W-1:0] REG_AXIS_U = 3'd1;
    localparam logic [IDX_W-1:0] REG_AXIS_V = 3'd2;
    localparam logic [IDX_W-1:0] REG_INNER  = 3'd3;
    localparam logic [IDX_W-1:0] REG_OUTER  = 3'd4;

    localparam logic [VEC_BITS-1:0]   CENTER_RST = 48'd0;
    localparam logic [VEC_BITS-1:0]   AXIS_U_RST = 48'd16384;
    localparam logic [VEC_BITS-1:0]   AXIS_V_RST = 48'd1073741824;
    localparam logic [COORD_BITS-1:0] INNER_RST  = 16'd256;
    localparam logic [COORD_BITS-1:0] OUTER_RST  = 16'd512;

    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic [VEC_BITS-1:0]   center;
        logic [VEC_BITS-1:0]   axis_u;
        logic [VEC_BITS-1:0]   axis_v;
        logic [COORD_BITS-1:0] inner;
        logic [COORD_BITS-1:0] outer;
    } rhpu_cfg_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [TURN_W-1:0] turn_angle(input int i);
        logic [TURN_W-1:0] a;
        case (i)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rhpu_front.sv @@
// Front end: center offset, squares and axis products, sums and hit test.
// Three register stages. Depends on rhpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhpu_front import rhpu_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [VEC_BITS-1:0]      point,
    input  wire rhpu_cfg_t                cfg,
    output logic        [D2_W-1:0]        d2,
    output logic signed [PROJ_W-1:0]      u,
    output logic signed [PROJ_W-1:0]      v,
    output logic                          hit
);

    logic signed [DIFF_W-1:0] d_reg  [3];
    logic signed [DIFF_W-1:0] d_next [3];
    logic        [SQ_W-1:0]   sq_reg [3];
    logic        [SQ_W-1:0]   sq_next[3];
    logic signed [PROD_W-1:0] pu_reg [3];
    logic signed [PROD_W-1:0] pu_next[3];
    logic signed [PROD_W-1:0] pv_reg [3];
    logic signed [PROD_W-1:0] pv_next[3];
    logic [SQ_W-1:0] rin2_reg, rin2_next, rout2_reg, rout2_next;
    logic [D2_W-1:0] d2_reg, d2_next;
    logic signed [PROJ_W-1:0] u_reg, u_next, v_reg, v_next;
    logic hit_reg, hit_next;

    always_comb begin
        logic signed [COORD_BITS-1:0] p, c, au, av;
        logic signed [2*DIFF_W-1:0] sq_full;
        for (int k = 0; k < 3; k++) begin
            p = point[k*COORD_BITS +: COORD_BITS];
            c = cfg.center[k*COORD_BITS +: COORD_BITS];
            d_next[k] = DIFF_W'(p) - DIFF_W'(c);
        end
        for (int k = 0; k < 3; k++) begin
            au = cfg.axis_u[k*AXIS_BITS +: AXIS_BITS];
            av = cfg.axis_v[k*AXIS_BITS +: AXIS_BITS];
            sq_full    = d_reg[k] * d_reg[k];
            sq_next[k] = sq_full[SQ_W-1:0];
            pu_next[k] = d_reg[k] * au;
            pv_next[k] = d_reg[k] * av;
        end
        rin2_next  = cfg.inner * cfg.inner;
        rout2_next = cfg.outer * cfg.outer;
        d2_next = D2_W'(sq_reg[0]) + D2_W'(sq_reg[1]) + D2_W'(sq_reg[2]);
        u_next  = PROJ_W'(pu_reg[0]) + PROJ_W'(pu_reg[1]) + PROJ_W'(pu_reg[2]);
        v_next  = PROJ_W'(pv_reg[0]) + PROJ_W'(pv_reg[1]) + PROJ_W'(pv_reg[2]);
        hit_next = (d2_next >= D2_W'(rin2_reg)) && (d2_next <= D2_W'(rout2_reg));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg     <= d_next;
            sq_reg    <= sq_next;
            pu_reg    <= pu_next;
            pv_reg    <= pv_next;
            rin2_reg  <= rin2_next;
            rout2_reg <= rout2_next;
            d2_reg    <= d2_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            hit_reg   <= hit_next;
        end
    end

    assign d2  = d2_reg;
    assign u   = u_reg;
    assign v   = v_reg;
    assign hit = hit_reg;

endmodule

`default_nettype wire

@@ hdl/rhpu_sqrt.sv @@
// Pipelined digit-by-digit integer square root of d2 << 16,
// one root bit per stage. Depends on rhpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhpu_sqrt import rhpu_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic [D2_W-1:0]     d2,
    output logic      [ROOT_W-1:0]   mag
);

    logic [REM_W-1:0]     rem_reg  [ROOT_W];
    logic [REM_W-1:0]     rem_next [ROOT_W];
    logic [ROOT_W-1:0]    root_reg [ROOT_W];
    logic [ROOT_W-1:0]    root_next[ROOT_W];
    logic [SQRT_IN_W-1:0] xb_reg   [ROOT_W];
    logic [SQRT_IN_W-1:0] xb_next  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        always_comb begin
            logic [REM_W-1:0]     rem_in;
            logic [ROOT_W-1:0]    root_in;
            logic [SQRT_IN_W-1:0] xb_in;
            logic [REM_W+1:0]     cur;
            logic [REM_W+1:0]     trial;
            if (j == 0) begin
                rem_in  = '0;
                root_in = '0;
                xb_in   = {d2, 16'd0};
            end else begin
                rem_in  = rem_reg[j-1];
                root_in = root_reg[j-1];
                xb_in   = xb_reg[j-1];
            end
            cur   = {rem_in, xb_in[SQRT_IN_W-1 -: 2]};
            trial = (REM_W+2)'({root_in, 2'b01});
            if (cur >= trial) begin
                rem_next[j]  = REM_W'(cur - trial);
                root_next[j] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[j]  = cur[REM_W-1:0];
                root_next[j] = {root_in[ROOT_W-2:0], 1'b0};
            end
            xb_next[j] = {xb_in[SQRT_IN_W-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                xb_reg[j]   <= xb_next[j];
            end
        end
    end

    assign mag = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

@@ hdl/rhpu_div.sv @@
// Radial coordinate: offset from inner radius over ring width, restoring
// division one quotient bit per stage with saturation. Depends on rhpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhpu_div import rhpu_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic [ROOT_W-1:0]   mag,
    input  wire rhpu_cfg_t           cfg,
    output logic      [RAD_W-1:0]    radial
);

    logic [COORD_BITS-1:0] width;
    logic zero_reg [DIV_LAT];
    logic sat_reg  [DIV_LAT];
    logic [COORD_BITS-1:0] r_reg  [DIV_LAT];
    logic [COORD_BITS-1:0] r_next [DIV_LAT];
    logic [RAD_W-1:0]      lo_reg [DIV_LAT];
    logic [RAD_W-1:0]      lo_next[DIV_LAT];
    logic [RAD_W-1:0]      q_reg  [DIV_LAT];
    logic [RAD_W-1:0]      q_next [DIV_LAT];
    logic zero_next, sat_next;

    assign width = cfg.outer - cfg.inner;

    // prep: numerator = mag - inner*256, quotient = num*256 / width
    always_comb begin
        logic [ROOT_W-1:0] rin_s, num;
        rin_s     = ROOT_W'({cfg.inner, 8'd0});
        num       = mag - rin_s;
        zero_next = !((cfg.outer > cfg.inner) && (mag > rin_s));
        sat_next  = num >= ROOT_W'({width, 8'd0});
        r_next[0]  = num[ROOT_W-2:8];
        lo_next[0] = {num[7:0], 8'd0};
        q_next[0]  = '0;
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
        always_comb begin
            logic [COORD_BITS:0] t;
            t = {r_reg[k-1], lo_reg[k-1][RAD_W-1]};
            if (t >= {1'b0, width}) begin
                r_next[k] = COORD_BITS'(t - {1'b0, width});
                q_next[k] = {q_reg[k-1][RAD_W-2:0], 1'b1};
            end else begin
                r_next[k] = t[COORD_BITS-1:0];
                q_next[k] = {q_reg[k-1][RAD_W-2:0], 1'b0};
            end
            lo_next[k] = {lo_reg[k-1][RAD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= zero_next;
            sat_reg[0]  <= sat_next;
            for (int k = 1; k < DIV_LAT; k++) begin
                zero_reg[k] <= zero_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
            end
            r_reg  <= r_next;
            lo_reg <= lo_next;
            q_reg  <= q_next;
        end
    end

    assign radial = zero_reg[DIV_LAT-1] ? '0 :
                    sat_reg[DIV_LAT-1]  ? '1 : q_reg[DIV_LAT-1];

endmodule

`default_nettype wire

@@ hdl/rhpu_cordic.sv @@
// Angle of (u, v) in turns: half-plane fold, then vectoring CORDIC with
// one micro-rotation per stage. Depends on rhpu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhpu_cordic import rhpu_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [PROJ_W-1:0] u,
    input  wire logic signed [PROJ_W-1:0] v,
    output logic             [ANG_W-1:0]  angle
);

    logic signed [CORD_W-1:0] x_reg [CORD_LAT];
    logic signed [CORD_W-1:0] x_next[CORD_LAT];
    logic signed [CORD_W-1:0] y_reg [CORD_LAT];
    logic signed [CORD_W-1:0] y_next[CORD_LAT];
    logic [TURN_W-1:0]        z_reg [CORD_LAT];
    logic [TURN_W-1:0]        z_next[CORD_LAT];
    logic                     zero_reg[CORD_LAT];
    logic                     zero_next;
    logic [TURN_W-1:0]        z_fin, ang_full;

    always_comb begin
        logic signed [CORD_W-1:0] xs, ys;
        xs = CORD_W'(u) <<< 8;
        ys = CORD_W'(v) <<< 8;
        zero_next = (u == '0) && (v == '0);
        if (xs < 0) begin
            x_next[0] = -xs;
            y_next[0] = -ys;
            z_next[0] = HALF_TURN;
        end else begin
            x_next[0] = xs;
            y_next[0] = ys;
            z_next[0] = '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        always_comb begin
            logic signed [CORD_W-1:0] xsh, ysh;
            xsh = x_reg[i] >>> i;
            ysh = y_reg[i] >>> i;
            if (y_reg[i] > 0) begin
                x_next[i+1] = x_reg[i] + ysh;
                y_next[i+1] = y_reg[i] - xsh;
                z_next[i+1] = z_reg[i] + turn_angle(i);
            end else begin
                x_next[i+1] = x_reg[i] - ysh;
                y_next[i+1] = y_reg[i] + xsh;
                z_next[i+1] = z_reg[i] - turn_angle(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            zero_reg[0] <= zero_next;
            for (int k = 1; k < CORD_LAT; k++) begin
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    // zero vector forces the CORDIC angle to 0; add half a turn, round to 16 bits
    assign z_fin    = zero_reg[CORD_LAT-1] ? '0 : z_reg[CORD_LAT-1];
    assign ang_full = z_fin + HALF_TURN + TURN_W'(32768);
    assign angle    = ang_full[TURN_W-1 -: ANG_W];

endmodule

`default_nettype wire

@@ hdl/ring_hit_test_and_polar_uv_core.sv @@
// Ring hit test with radial and angular texture coordinates.
// Accepts one input word per cycle while the output is not stalled. The whole
// pipeline advances together and holds while the output word waits. Reset
// (aresetn low, synchronous) clears the valid bits and restores the
// configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module ring_hit_test_and_polar_uv_core import rhpu_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,   // point_x, point_y, point_z
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [39:0]               m_tdata,   // hit, radial_coord, angle_coord, zero pad
    input  wire logic                 cfg_wr_en,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_BITS-1:0]  cfg_data
);

    rhpu_cfg_t cfg_reg;
    logic en;
    logic [TOTAL_LAT-1:0] valid_reg;

    logic [D2_W-1:0]          d2;
    logic signed [PROJ_W-1:0] u, v;
    logic                     hit_f;
    logic [ROOT_W-1:0]        mag;
    logic [RAD_W-1:0]         radial;
    logic [ANG_W-1:0]         angle;
    logic                     hit_dly_reg [HIT_DLY];
    logic [ANG_W-1:0]         ang_dly_reg [ANG_DLY];

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center <= CENTER_RST;
            cfg_reg.axis_u <= AXIS_U_RST;
            cfg_reg.axis_v <= AXIS_V_RST;
            cfg_reg.inner  <= INNER_RST;
            cfg_reg.outer  <= OUTER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER: cfg_reg.center <= cfg_data[VEC_BITS-1:0];
                REG_AXIS_U: cfg_reg.axis_u <= cfg_data[VEC_BITS-1:0];
                REG_AXIS_V: cfg_reg.axis_v <= cfg_data[VEC_BITS-1:0];
                REG_INNER:  cfg_reg.inner  <= cfg_data[COORD_BITS-1:0];
                REG_OUTER:  cfg_reg.outer  <= cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    rhpu_front u_front (
        .aclk  (aclk),
        .en    (en),
        .point (s_tdata[VEC_BITS-1:0]),
        .cfg   (cfg_reg),
        .d2    (d2),
        .u     (u),
        .v     (v),
        .hit   (hit_f)
    );

    rhpu_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .d2   (d2),
        .mag  (mag)
    );

    rhpu_div u_div (
        .aclk   (aclk),
        .en     (en),
        .mag    (mag),
        .cfg    (cfg_reg),
        .radial (radial)
    );

    rhpu_cordic u_cordic (
        .aclk  (aclk),
        .en    (en),
        .u     (u),
        .v     (v),
        .angle (angle)
    );

    // align hit and angle with the radial path
    always_ff @(posedge aclk) begin
        if (en) begin
            hit_dly_reg[0] <= hit_f;
            for (int k = 1; k < HIT_DLY; k++) begin
                hit_dly_reg[k] <= hit_dly_reg[k-1];
            end
            ang_dly_reg[0] <= angle;
            for (int k = 1; k < ANG_DLY; k++) begin
                ang_dly_reg[k] <= ang_dly_reg[k-1];
            end
        end
    end

    assign m_tvalid = valid_reg[TOTAL_LAT-1];
    assign m_tdata  = {7'd0, ang_dly_reg[ANG_DLY-1], radial, hit_dly_reg[HIT_DLY-1]};

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(valid_reg))
        else $error("pipeline moved during stall");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !valid_reg[TOTAL_LAT-2] |=> !m_tvalid)
        else $error("output word repeated");
`endif

endmodule

`default_nettype wire
